// ----- rtl/core/urd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_pkg
// Shared constants and types for the unique random draw block.
// ----------------------------------------------------------------------------
package urd_pkg;

  localparam int MAX_DRAWS = 10;
  localparam int CNT_W     = $clog2(MAX_DRAWS + 1);
  localparam int HIST_W    = 7;
  localparam int LFSR_W    = 16;
  localparam int TRY_W     = 16;
  localparam int DIGIT_W   = 4;

  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd42;
  localparam logic [HIST_W-1:0] NUM_RANGE  = 7'd100;

  // Reciprocal of 100 scaled by 2^24 and rounded up; exact for 16-bit values.
  localparam int                 RECIP_SHIFT = 24;
  localparam logic [17:0]        RECIP_K     = 18'd167773;
  localparam int                 QUOT_W      = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_RED,
    ST_WALK,
    ST_EMIT
  } urd_state_e;

  // Candidate travelling along the history cells.
  typedef struct packed {
    logic              vld;
    logic [HIST_W-1:0] val;
    logic              hit;
  } urd_tok_t;

endpackage

// ----- rtl/core/unique_random_draw.sv -----
`timescale 1ns / 1ps
// An item without a draw goes to the emit state, which waits until the output is free.
// A draw first runs generator tries until it finds a new number or the tries run out. Each
// try steps the generator, runs the reduction and walks the ten history cells, one cell per cycle.
// One item is in work at a time and the output word is registered. The next word
// can be taken in the same cycle that the output word appears.
// Reset loads the shift register with 42, clears the count and sets the held digits to 99.
// ----------------------------------------------------------------------------
// unique_random_draw
// Push-button number picker that never repeats a number until the limit.
// ----------------------------------------------------------------------------
module unique_random_draw import urd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [LFSR_W-1:0] cfg_wr_data_i,    // seed
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,     // [0] button_level, rest zero
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,     // [3:0] digit_units, [7:4] digit_tens
  output logic [1:0]        m_axis_tuser      // [0] new_draw, [1] all_drawn
);

  urd_state_e         st_q, st_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TRY_W-1:0]   tries_q, tries_d;
  logic [DIGIT_W-1:0] units_q, units_d, tens_q, tens_d;
  logic               fresh_q, fresh_d;
  logic               m_valid_q, m_valid_d;
  logic [7:0]         m_data_q, m_data_d;
  logic [1:0]         m_user_q, m_user_d;

  logic               step;
  logic               res_vld;
  logic [HIST_W-1:0]  res;
  logic               commit;
  logic               limit;
  logic               out_free;
  logic [DIGIT_W-1:0] new_tens;
  logic [HIST_W-1:0]  new_units;

  urd_tok_t           tok [MAX_DRAWS+1];
  logic [MAX_DRAWS-1:0] tok_vld;

  urd_rng u_rng (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (cfg_wr_en_i),
    .seed_i    (cfg_wr_data_i),
    .step_i    (step),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign tok[0] = '{vld: res_vld, val: res, hit: 1'b0};

  for (genvar i = 0; i < MAX_DRAWS; i++) begin : g_cell
    urd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .armed_i  (cnt_q > CNT_W'(i)),
      .wr_en_i  (commit && (cnt_q == CNT_W'(i))),
      .wr_val_i (tok[MAX_DRAWS].val),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  assign limit    = (cnt_q >= CNT_W'(MAX_DRAWS));
  assign out_free = !m_valid_q || m_axis_tready;

  // Tens digit by counting the decade thresholds the value has passed.
  always_comb begin
    new_tens = '0;
    for (int k = 1; k < 10; k++) begin
      if (tok[MAX_DRAWS].val >= HIST_W'(10 * k)) begin
        new_tens = new_tens + DIGIT_W'(1);
      end
    end
    new_units = tok[MAX_DRAWS].val - (HIST_W'(new_tens) << 3) - (HIST_W'(new_tens) << 1);
  end

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    tries_d   = tries_q;
    units_d   = units_q;
    tens_d    = tens_q;
    fresh_d   = fresh_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    step      = 1'b0;
    commit    = 1'b0;
    s_axis_tready = (st_q == ST_IDLE);

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          fresh_d = 1'b0;
          tries_d = '0;
          if (s_axis_tdata[0] && !limit) begin
            st_d = ST_STEP;
          end else begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_STEP: begin
        step = 1'b1;
        st_d = ST_RED;
      end
      ST_RED: begin
        if (res_vld) begin
          st_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok[MAX_DRAWS].vld) begin
          if (!tok[MAX_DRAWS].hit) begin
            commit  = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
            tens_d  = new_tens;
            units_d = new_units[DIGIT_W-1:0];
            fresh_d = 1'b1;
            st_d    = ST_EMIT;
          end else if (tries_q == {TRY_W{1'b1}}) begin
            // Generator exhausted: the draw is given up.
            st_d = ST_EMIT;
          end else begin
            tries_d = tries_q + TRY_W'(1);
            st_d    = ST_STEP;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {tens_q, units_q};
          m_user_d  = {limit, fresh_q};
          st_d      = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      tries_q   <= '0;
      units_q   <= DIGIT_W'(9);
      tens_q    <= DIGIT_W'(9);
      fresh_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      tries_q   <= tries_d;
      units_q   <= units_d;
      tens_q    <= tens_d;
      fresh_q   <= fresh_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Only one candidate is ever travelling along the cells.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one candidate in the history chain");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DRAWS))
    else $error("draw count beyond the limit");

  a_no_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !(|tok_vld) && !res_vld)
    else $error("generator stepped while a candidate is still checked");

  a_fresh_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("committed draw not counted");

  a_fresh_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_user_q[0] |-> cnt_q != '0)
    else $error("fresh word reported with an empty history");

endmodule

// ----- rtl/core/urd_rng.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_rng
// 16-bit Fibonacci shift register with a pipelined reduction modulo 100.
// ----------------------------------------------------------------------------
module urd_rng import urd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [LFSR_W-1:0] seed_i,
  input  logic              step_i,
  output logic              res_vld_o,
  output logic [HIST_W-1:0] res_o
);

  logic [LFSR_W-1:0]              lfsr_q, lfsr_d;
  logic                           v1_q, v2_q, v3_q;
  logic [LFSR_W-1:0]              x_q;
  logic [QUOT_W-1:0]              quot_q;
  logic [HIST_W-1:0]              res_q;
  logic [LFSR_W+17:0]             prod;
  logic [LFSR_W:0]                back;
  logic [LFSR_W:0]                rem;

  always_comb begin
    lfsr_d = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};
  end

  assign prod = {{18{1'b0}}, lfsr_q} * {{LFSR_W{1'b0}}, RECIP_K};
  assign back = (LFSR_W+1)'(quot_q) * (LFSR_W+1)'(NUM_RANGE);
  assign rem  = {1'b0, x_q} - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SEED_RESET;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (load_i) begin
        lfsr_q <= seed_i;
      end else if (step_i) begin
        lfsr_q <= lfsr_d;
      end
      v1_q <= step_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Quotient first, then the remainder, each behind its own register.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      x_q    <= lfsr_q;
      quot_q <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (v2_q) begin
      res_q <= rem[HIST_W-1:0];
    end
  end

  assign res_vld_o = v3_q;
  assign res_o     = res_q;

endmodule

// ----- rtl/core/urd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_cell
// One history entry; compares a passing candidate and hands it on.
// ----------------------------------------------------------------------------
module urd_cell import urd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              armed_i,
  input  logic              wr_en_i,
  input  logic [HIST_W-1:0] wr_val_i,
  input  urd_tok_t          tok_i,
  output urd_tok_t          tok_o
);

  logic [HIST_W-1:0] entry_q;
  logic              vld_q;
  logic [HIST_W-1:0] val_q;
  logic              hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_val_i;
    end
    // An entry that has not been written yet is never armed.
    val_q <= tok_i.val;
    hit_q <= tok_i.hit | (armed_i & (entry_q == tok_i.val));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  assign tok_o = '{vld: vld_q, val: val_q, hit: hit_q};

endmodule
